@@ hdl/vtdi_pkg.sv @@
// Package for the VLAN tag demux and insert block.
// Holds item kinds, sizes, tag constants and the controller command struct.
package vtdi_pkg;
	localparam int PORT_COUNT_DEF = 32;
	localparam int VID_SPACE_DEF  = 4096;
	localparam int HOLD_LEN       = 16;
	localparam int MAC_LEN        = 12;
	localparam logic [15:0] TAG_TYPE = 16'h8100;
	localparam logic [11:0] VID_MASK = 12'hfff;

	localparam logic [1:0] KIND_MAP   = 2'd0;
	localparam logic [1:0] KIND_TRUNK = 2'd1;
	localparam logic [1:0] KIND_PORT  = 2'd2;
	localparam logic [1:0] KIND_RSVD  = 2'd3;

	// Output source selects.
	localparam logic [1:0] SRC_IN   = 2'd0;
	localparam logic [1:0] SRC_HOLD = 2'd1;
	localparam logic [1:0] SRC_TAG  = 2'd2;

	// Commands from controller to datapath.
	typedef struct packed {
		logic       in_load;    // capture input item into datapath registers
		logic       hold_wr;    // write captured byte into header hold
		logic       map_wr;     // write both map tables
		logic       vid_rd;     // start lookup of VID from held header
		logic       emit;       // present one result
		logic [1:0] src;        // result byte source
		logic [3:0] idx;        // hold index or tag byte index
		logic [4:0] dest;
		logic       trunk;
		logic       last;
	} vtdi_cmd_t;

	// Status from datapath to controller.
	typedef struct packed {
		logic       vlan_hit;   // held ethertype equals tag type
		logic [4:0] lookup_port;
		logic [1:0] kind;
		logic [4:0] port;
		logic       eof;
		logic       clr_done;   // VID table clearing pass after reset is finished
	} vtdi_stat_t;
endpackage

@@ hdl/vtdi_datapath.sv @@
// Datapath: captured item, header hold, map tables and result byte selection.
// Depends on vtdi_pkg.
module vtdi_datapath import vtdi_pkg::*; #(
	parameter int PORT_COUNT = PORT_COUNT_DEF,
	parameter int VID_SPACE  = VID_SPACE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  in_kind,
	input  logic [7:0]  in_byte,
	input  logic [4:0]  in_port,
	input  logic [11:0] in_vid,
	input  logic        in_eof,
	input  vtdi_cmd_t   cmd,
	output vtdi_stat_t  stat,
	output logic [7:0]  res_byte
);
	localparam int PW = $clog2(PORT_COUNT);
	localparam int VW = $clog2(VID_SPACE);

	logic [1:0]  kind_q;
	logic [7:0]  byte_q;
	logic [4:0]  port_q;
	logic [11:0] vid_q;
	logic        eof_q;
	logic [7:0]  hold_q [HOLD_LEN];
	logic [4:0]  vid_port_mem [VID_SPACE];
	logic [11:0] port_vid_q [PORT_COUNT];
	logic [4:0]  lookup_q;
	logic [VW:0] clr_q;
	logic [VW-1:0] rd_addr;
	logic [11:0] pv;
	logic        in_range;

	// Capture of the accepted item.
	always_ff @(posedge clk) begin
		if (cmd.in_load) begin
			kind_q <= in_kind;
			byte_q <= in_byte;
			port_q <= in_port;
			vid_q  <= in_vid;
			eof_q  <= in_eof;
		end
	end

	assign in_range = (port_q != 5'd0) && ({27'd0, port_q} < PORT_COUNT);

	// Header hold.
	always_ff @(posedge clk) begin
		if (cmd.hold_wr) begin
			hold_q[cmd.idx] <= byte_q;
		end
	end

	// Port to VID table, small and reset to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PORT_COUNT; i++) port_vid_q[i] <= '0;
		end else if (cmd.map_wr && in_range) begin
			port_vid_q[port_q[PW-1:0]] <= vid_q;
		end
	end

	// Clearing pass counter: walks every VID entry once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (!clr_q[VW]) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	// VID to port memory; zeroed by the clearing pass, then written by map items.
	assign rd_addr = VW'({hold_q[14], hold_q[15]} & {4'd0, VID_MASK});
	always_ff @(posedge clk) begin
		if (!clr_q[VW]) begin
			vid_port_mem[clr_q[VW-1:0]] <= '0;
		end else if (cmd.map_wr && in_range) begin
			vid_port_mem[vid_q[VW-1:0]] <= port_q;
		end
		if (cmd.vid_rd) begin
			lookup_q <= vid_port_mem[rd_addr];
		end
	end

	// Result byte selection.
	assign pv = port_vid_q[port_q[PW-1:0]];
	always_comb begin
		unique case (cmd.src)
			SRC_HOLD: res_byte = hold_q[cmd.idx];
			SRC_TAG: begin
				unique case (cmd.idx[1:0])
					2'd0:    res_byte = TAG_TYPE[15:8];
					2'd1:    res_byte = TAG_TYPE[7:0];
					2'd2:    res_byte = {4'd0, pv[11:8]};
					default: res_byte = pv[7:0];
				endcase
			end
			default: res_byte = byte_q;
		endcase
	end

	assign stat.vlan_hit    = ({hold_q[12], hold_q[13]} == TAG_TYPE);
	assign stat.lookup_port = lookup_q;
	assign stat.kind        = kind_q;
	assign stat.port        = port_q;
	assign stat.eof         = eof_q;
	assign stat.clr_done    = clr_q[VW];
endmodule

@@ hdl/vtdi_ctrl.sv @@
// Controller state machine: sequences capture, lookups and result bursts.
// Depends on vtdi_pkg.
module vtdi_ctrl import vtdi_pkg::*; #(
	parameter int PORT_COUNT = PORT_COUNT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_fire,
	input  logic       out_busy,
	input  vtdi_stat_t stat,
	output logic       s_ready,
	output vtdi_cmd_t  cmd
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PROC = 3'd1;
	localparam logic [2:0] ST_LOOK = 3'd2;
	localparam logic [2:0] ST_FLSH = 3'd3;
	localparam logic [2:0] ST_TAG  = 3'd4;

	logic [2:0] state_q, state_d;
	logic [4:0] tpos_q, tpos_d;
	logic [4:0] tport_q, tport_d;
	logic [3:0] upos_q, upos_d;
	logic [3:0] cnt_q, cnt_d;
	logic [4:0] flen_q, flen_d;
	logic [4:0] fdest_q, fdest_d;
	logic       feof_q, feof_d;
	logic       native;
	logic [4:0] lp;

	assign native = (stat.port == 5'd0) || ({27'd0, stat.port} >= PORT_COUNT);
	assign lp = ({27'd0, stat.lookup_port} >= PORT_COUNT) ? 5'd0 : stat.lookup_port;
	assign s_ready = (state_q == ST_IDLE) && stat.clr_done;

	// Next-state and command logic.
	always_comb begin
		state_d = state_q;
		tpos_d  = tpos_q;
		tport_d = tport_q;
		upos_d  = upos_q;
		cnt_d   = cnt_q;
		flen_d  = flen_q;
		fdest_d = fdest_q;
		feof_d  = feof_q;
		cmd     = '0;
		cmd.in_load = s_fire;
		unique case (state_q)
			ST_IDLE: if (s_fire) state_d = ST_PROC;
			ST_PROC: begin
				priority if (stat.kind == KIND_MAP) begin
					cmd.map_wr = 1'b1;
					state_d = ST_IDLE;
				end else if (stat.kind == KIND_TRUNK) begin
					if (tpos_q == 5'(HOLD_LEN)) begin
						if (!out_busy) begin
							cmd.emit = 1'b1; cmd.src = SRC_IN;
							cmd.dest = tport_q; cmd.last = stat.eof;
							if (stat.eof) tpos_d = '0;
							state_d = ST_IDLE;
						end
					end else begin
						cmd.hold_wr = 1'b1;
						cmd.idx = tpos_q[3:0];
						if (tpos_q == 5'(HOLD_LEN - 1)) begin
							feof_d = stat.eof;
							state_d = ST_LOOK;
						end else if (stat.eof) begin
							tport_d = '0; tpos_d = '0;
							flen_d = tpos_q + 5'd1; fdest_d = '0; feof_d = 1'b1;
							cnt_d = '0; state_d = ST_FLSH;
						end else begin
							tpos_d = tpos_q + 5'd1;
							state_d = ST_IDLE;
						end
					end
				end else if (stat.kind == KIND_PORT) begin
					if (!out_busy) begin
						cmd.emit = 1'b1; cmd.src = SRC_IN; cmd.trunk = 1'b1;
						if (upos_q == 4'(MAC_LEN - 1) && !native) begin
							cnt_d = '0; state_d = ST_TAG;
						end else begin
							cmd.last = stat.eof;
							state_d = ST_IDLE;
							if (stat.eof) upos_d = '0;
							else if (upos_q < 4'(MAC_LEN)) upos_d = upos_q + 4'd1;
						end
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_LOOK: begin
				// Lookup address comes from the held header; the registered result is valid in the next cycle.
				cmd.vid_rd = 1'b1;
				cnt_d = '0;
				state_d = ST_FLSH;
				flen_d = 5'h1f;
			end
			ST_FLSH: begin
				if (flen_q == 5'h1f) begin
					// Lookup result just arrived; settle the destination.
					fdest_d = stat.vlan_hit ? lp : 5'd0;
					tport_d = fdest_d;
					flen_d = (fdest_d != 5'd0) ? 5'(MAC_LEN) : 5'(HOLD_LEN);
					tpos_d = feof_q ? 5'd0 : 5'(HOLD_LEN);
				end else if (!out_busy) begin
					cmd.emit = 1'b1; cmd.src = SRC_HOLD; cmd.idx = cnt_q;
					cmd.dest = fdest_q;
					cmd.last = feof_q && ({1'b0, cnt_q} + 5'd1 == flen_q);
					cnt_d = cnt_q + 4'd1;
					if ({1'b0, cnt_q} + 5'd1 == flen_q) state_d = ST_IDLE;
				end
			end
			ST_TAG: begin
				if (!out_busy) begin
					cmd.emit = 1'b1; cmd.src = SRC_TAG; cmd.idx = cnt_q; cmd.trunk = 1'b1;
					cmd.last = stat.eof && (cnt_q == 4'd3);
					cnt_d = cnt_q + 4'd1;
					if (cnt_q == 4'd3) begin
						state_d = ST_IDLE;
						upos_d = stat.eof ? 4'd0 : 4'(MAC_LEN);
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			tpos_q  <= '0;
			tport_q <= '0;
			upos_q  <= '0;
			cnt_q   <= '0;
			flen_q  <= '0;
			fdest_q <= '0;
			feof_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			tpos_q  <= tpos_d;
			tport_q <= tport_d;
			upos_q  <= upos_d;
			cnt_q   <= cnt_d;
			flen_q  <= flen_d;
			fdest_q <= fdest_d;
			feof_q  <= feof_d;
		end
	end
endmodule

@@ hdl/vlan_tag_demux_and_insert_top.sv @@
// VLAN tag demux and insert, top level. Depends on vtdi_pkg, vtdi_ctrl, vtdi_datapath.
// An accepted item is captured, then decoded; any result goes to the output register;
// further burst results follow while the output is not stalled. The 16th trunk header
// byte first passes the VID table read (ST_LOOK) and destination decision (ST_FLSH);
// a short trunk frame's last byte goes to ST_FLSH. Items are taken only in idle, not
// during decode or a burst. Reset (arst_n low, asynchronous) clears control state, then
// s_tready stays low during a pass that zeroes every VID table entry.
module vlan_tag_demux_and_insert_top import vtdi_pkg::*; #(
	parameter int PORT_COUNT = PORT_COUNT_DEF,
	parameter int VID_SPACE  = VID_SPACE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // data_byte[7:0], port_index[12:8], vlan_id[24:13], zero
	input  logic [1:0]  s_tuser,  // kind[1:0]
	input  logic        s_tlast,  // end_of_frame
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // out_byte[7:0], dest_port[12:8], zero
	output logic        m_tuser,  // to_trunk
	output logic        m_tlast   // out_last
);
	vtdi_cmd_t  cmd;
	vtdi_stat_t stat;
	logic [7:0] res_byte;
	logic       s_fire;
	logic       out_busy;
	logic [7:0] ob_q;
	logic [4:0] od_q;
	logic       ot_q, ol_q;

	assign s_fire = s_tvalid && s_tready;
	assign out_busy = m_tvalid && !m_tready;

	vtdi_ctrl #(.PORT_COUNT(PORT_COUNT)) u_ctrl (
		.clk, .arst_n, .s_fire, .out_busy, .stat, .s_ready(s_tready), .cmd
	);

	vtdi_datapath #(.PORT_COUNT(PORT_COUNT), .VID_SPACE(VID_SPACE)) u_dp (
		.clk, .arst_n,
		.in_kind(s_tuser), .in_byte(s_tdata[7:0]), .in_port(s_tdata[12:8]),
		.in_vid(s_tdata[24:13]), .in_eof(s_tlast),
		.cmd, .stat, .res_byte
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			ob_q <= res_byte;
			od_q <= cmd.dest;
			ot_q <= cmd.trunk;
			ol_q <= cmd.last;
		end
	end

	assign m_tdata = {3'd0, od_q, ob_q};
	assign m_tuser = ot_q;
	assign m_tlast = ol_q;
endmodule

@@ dv/tb_vlan_tag_demux_and_insert_top.sv @@
// Self-checking testbench for the VLAN tag demux and insert block.
// Predicts every result item from the map writes and frame bytes it sends.
// Depends on vtdi_pkg and vlan_tag_demux_and_insert_top.
module tb_vlan_tag_demux_and_insert_top import vtdi_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NPORT = 32;
	localparam int IDLE_LIMIT = 20000;

	typedef struct packed {
		logic [7:0] byte_val;
		logic [4:0] dest;
		logic       trunk;
		logic       last;
	} vtdi_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	vlan_tag_demux_and_insert_top dut (.*);

	always #5 clk = ~clk;

	// Predictor state.
	logic [4:0]  vid_to_port [VID_SPACE_DEF];
	logic [11:0] port_to_vid [NPORT];
	logic [7:0]  hdr [HOLD_LEN];
	int          trunk_pos;
	logic [4:0]  trunk_port;
	int          up_pos;
	vtdi_res_t   expected_q[$];

	int errors = 0;
	int idle_cycles = 0;
	logic rx_random = 1'b1;

	function automatic vtdi_res_t mk(logic [7:0] b, logic [4:0] d, logic t, logic l);
		vtdi_res_t r;
		r.byte_val = b; r.dest = d; r.trunk = t; r.last = l;
		return r;
	endfunction

	// Compute the results caused by one accepted item.
	task automatic predict_item(logic [1:0] kind, logic [7:0] b, logic [4:0] p,
			logic [11:0] vid, logic eof);
		logic [4:0]  port;
		logic [11:0] v;
		int n;
		case (kind)
			KIND_MAP: begin
				if (p != 0) begin
					port_to_vid[p] = vid;
					vid_to_port[vid] = p;
				end
			end
			KIND_TRUNK: begin
				if (trunk_pos >= HOLD_LEN) begin
					expected_q.push_back(mk(b, trunk_port, 1'b0, eof));
					if (eof) trunk_pos = 0;
				end else begin
					hdr[trunk_pos] = b;
					trunk_pos++;
					if (trunk_pos == HOLD_LEN) begin
						port = 0;
						if ({hdr[12], hdr[13]} == TAG_TYPE)
							port = vid_to_port[{hdr[14][3:0], hdr[15]}];
						trunk_port = port;
						n = (port != 0) ? MAC_LEN : HOLD_LEN;
						for (int i = 0; i < n; i++)
							expected_q.push_back(mk(hdr[i], port, 1'b0, eof && i == n - 1));
						trunk_pos = eof ? 0 : HOLD_LEN;
					end else if (eof) begin
						trunk_port = 0;
						for (int i = 0; i < trunk_pos; i++)
							expected_q.push_back(mk(hdr[i], 5'd0, 1'b0, i == trunk_pos - 1));
						trunk_pos = 0;
					end
				end
			end
			KIND_PORT: begin
				if (up_pos == MAC_LEN - 1 && p != 0) begin
					v = port_to_vid[p];
					expected_q.push_back(mk(b, 5'd0, 1'b1, 1'b0));
					expected_q.push_back(mk(TAG_TYPE[15:8], 5'd0, 1'b1, 1'b0));
					expected_q.push_back(mk(TAG_TYPE[7:0], 5'd0, 1'b1, 1'b0));
					expected_q.push_back(mk({4'd0, v[11:8]}, 5'd0, 1'b1, 1'b0));
					expected_q.push_back(mk(v[7:0], 5'd0, 1'b1, eof));
				end else begin
					expected_q.push_back(mk(b, 5'd0, 1'b1, eof));
				end
				if (eof) up_pos = 0;
				else if (up_pos < MAC_LEN) up_pos++;
			end
			default: ;
		endcase
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 3) == 0) return 0;
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	// Send one item and predict its results; valid stays up only across back-to-back items.
	task automatic send_item(logic [1:0] kind, logic [7:0] b, logic [4:0] p,
			logic [11:0] vid, logic eof);
		int gap;
		gap = gap_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, vid, p, b};
		s_tuser <= kind;
		s_tlast <= eof;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predict_item(kind, b, p, vid, eof);
	endtask

	task automatic send_trunk_frame(logic [15:0] etype, logic [11:0] vid, int len);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			b = 8'($urandom);
			if (i == 12) b = etype[15:8];
			if (i == 13) b = etype[7:0];
			if (i == 14) b = {4'($urandom_range(0, 15)), vid[11:8]};
			if (i == 15) b = vid[7:0];
			send_item(KIND_TRUNK, b, 5'($urandom), 12'($urandom), i == len - 1);
		end
	endtask

	task automatic send_port_frame(logic [4:0] p, int len);
		for (int i = 0; i < len; i++)
			send_item(KIND_PORT, 8'($urandom), p, 12'($urandom), i == len - 1);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Directed: field extremes, each kind, short and exact-length frames.
	task automatic test_directed();
		send_item(KIND_MAP, 8'hff, 5'd0, 12'hfff, 1'b1);
		send_item(KIND_MAP, 8'h00, 5'd31, 12'hfff, 1'b1);
		send_item(KIND_MAP, 8'h00, 5'd1, 12'h000, 1'b0);
		send_item(KIND_MAP, 8'h00, 5'd1, 12'h5a5, 1'b0);
		send_item(KIND_RSVD, 8'hff, 5'd31, 12'hfff, 1'b1);
		send_trunk_frame(TAG_TYPE, 12'hfff, 16);
		send_trunk_frame(TAG_TYPE, 12'h5a5, 18);
		send_trunk_frame(TAG_TYPE, 12'h123, 17);
		send_trunk_frame(16'h0800, 12'hfff, 17);
		send_trunk_frame(16'h0800, 12'h0, 3);
		send_item(KIND_TRUNK, 8'h00, 5'd0, 12'd0, 1'b1);
		send_port_frame(5'd31, 13);
		send_port_frame(5'd1, 12);
		send_port_frame(5'd0, 14);
		send_port_frame(5'd2, 5);
		wait_drain();
	endtask

	// Random mix of well-formed frames, map writes and noise.
	task automatic test_random();
		int sent;
		int sel;
		logic [4:0] p;
		sent = 0;
		while (sent < 140) begin
			sel = $urandom_range(0, 9);
			p = 5'($urandom);
			if (sel < 2) begin
				send_item(KIND_MAP, 8'($urandom), p, 12'($urandom), 1'($urandom));
				sent++;
			end else if (sel < 5) begin
				send_trunk_frame($urandom_range(0, 4) != 0 ? TAG_TYPE : 16'($urandom),
					port_to_vid[p], $urandom_range(0, 5) == 0 ?
					$urandom_range(1, 16) : $urandom_range(16, 22));
				sent += 16;
			end else if (sel < 8) begin
				send_port_frame($urandom_range(0, 5) == 0 ? 5'd0 : p,
					$urandom_range(0, 5) == 0 ? $urandom_range(1, 11) :
					$urandom_range(12, 18));
				sent += 12;
			end else if (sel == 8) begin
				send_item(KIND_PORT, 8'($urandom), 5'($urandom), 12'($urandom),
					1'($urandom));
				sent++;
			end else begin
				send_item(KIND_RSVD, 8'($urandom), 5'($urandom), 12'($urandom),
					1'($urandom));
			end
		end
	endtask

	// Hold off the sender until every result has come, then resume with the receiver always ready.
	task automatic test_full_drain();
		send_trunk_frame(TAG_TYPE, port_to_vid[1], 20);
		wait_drain();
		rx_random = 1'b0;
		send_port_frame(5'd1, 16);
		rx_random = 1'b1;
	endtask

	// Result checker.
	always @(posedge clk) begin
		vtdi_res_t got;
		vtdi_res_t exp_r;
		if (m_tvalid && m_tready) begin
			got = mk(m_tdata[7:0], m_tdata[12:8], m_tuser, m_tlast);
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
			end else begin
				exp_r = expected_q.pop_front();
				if (got !== exp_r) begin
					errors++;
					if (errors <= 10) begin
						$display("mismatch: expected byte %h dest %0d trunk %b last %b,",
							exp_r.byte_val, exp_r.dest, exp_r.trunk, exp_r.last);
						$display("          got byte %h dest %0d trunk %b last %b",
							got.byte_val, got.dest, got.trunk, got.last);
					end
				end
			end
		end
	end

	// Receiver stalls.
	always @(posedge clk) begin
		if (!rx_random) m_tready <= 1'b1;
		else if ($urandom_range(0, 49) == 0) m_tready <= 1'b0;
		else m_tready <= $urandom_range(0, 3) != 0;
	end

	// Watchdog on cycles without any accepted item or result.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < VID_SPACE_DEF; i++) vid_to_port[i] = '0;
		for (int i = 0; i < NPORT; i++) port_to_vid[i] = '0;
		for (int i = 0; i < HOLD_LEN; i++) hdr[i] = '0;
		trunk_pos = 0;
		trunk_port = '0;
		up_pos = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random();
		test_full_drain();
		wait_drain();
		if (errors == 0 && expected_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
